[design/hhr_pkg.sv]
package hhr_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  // 2*pi in Q16
  localparam int TWO_PI_Q16 = 411775;
  localparam int KB = 19;

  // derived widths
  localparam int DW   = COORD_BITS + 1;      // axis offsets
  localparam int CW   = COORD_BITS + 4;      // rotation datapath
  localparam int SQW  = 2 * DW;              // sum of squares
  localparam int RTW  = DW;                  // root bits
  localparam int RMW  = RTW + 3;             // root remainder
  localparam int NSQ  = DW;                  // root digit steps
  localparam int NCOR = 32;                  // rotation steps
  localparam int NST  = (NCOR > NSQ + 1) ? NCOR : NSQ + 1;
  localparam int OW   = COORD_BITS + 1;      // result width
  localparam int PW   = COORD_BITS + KB - 15; // pitch width
  localparam int QW   = COORD_BITS + ANGLE_BITS + 1;
  localparam int UW   = COORD_BITS + ANGLE_BITS + 6;
  localparam int RW   = COORD_BITS + 9;

  // register indexes
  localparam logic [2:0] REG_AXIS_X  = 3'd0;
  localparam logic [2:0] REG_AXIS_Z  = 3'd1;
  localparam logic [2:0] REG_RADIUS  = 3'd2;
  localparam logic [2:0] REG_RISE    = 3'd3;
  localparam logic [2:0] REG_START_X = 3'd4;
  localparam logic [2:0] REG_START_Z = 3'd5;
  localparam logic [2:0] REG_START_Y = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] c;
    logic [31:0]          a;
  } cor_t;

  typedef struct packed {
    cor_t                         hit;
    cor_t                         sta;
    logic                         hz;
    logic                         sz;
    logic [SQW-1:0]               val;
    logic [RMW-1:0]               rem;
    logic [RTW-1:0]               root;
    logic signed [COORD_BITS-1:0] hy;
  } stg_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [31:0] turn_tab(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      24: t = 32'd41;
      25: t = 32'd20;
      26: t = 32'd10;
      27: t = 32'd5;
      28: t = 32'd3;
      29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // fold a left half plane point into the right half plane
  function automatic cor_t cor_prep(input logic signed [DW-1:0] sv,
                                    input logic signed [DW-1:0] cv);
    cor_t o;
    if (cv < 0) begin
      o.s = -CW'(sv);
      o.c = -CW'(cv);
      o.a = 32'h8000_0000;
    end else begin
      o.s = CW'(sv);
      o.c = CW'(cv);
      o.a = 32'd0;
    end
    return o;
  endfunction

  function automatic cor_t cor_step(input cor_t x, input int i);
    cor_t o;
    logic signed [CW-1:0] ds;
    logic signed [CW-1:0] dc;
    ds = x.s >>> i;
    dc = x.c >>> i;
    if (x.s > 0) begin
      o.c = x.c + ds;
      o.s = x.s - dc;
      o.a = x.a + turn_tab(i);
    end else begin
      o.c = x.c - ds;
      o.s = x.s + dc;
      o.a = x.a - turn_tab(i);
    end
    return o;
  endfunction

  // round the turn accumulator to the angle width
  function automatic logic signed [ANGLE_BITS-1:0] ang_round(input logic [31:0] a,
                                                             input logic zero);
    logic [31:0] r;
    r = a + (32'd1 << (31 - ANGLE_BITS));
    return zero ? '0 : $signed(r[31 -: ANGLE_BITS]);
  endfunction

  function automatic logic [OW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] t;
    hi = (64'sd1 <<< COORD_BITS) - 64'sd1;
    lo = -(64'sd1 <<< COORD_BITS);
    t = v;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[OW-1:0];
  endfunction

endpackage

[design/hhr_if.sv]
interface hhr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hhr_pkg::COORD_BITS-1:0] hit_x;
  logic signed [hhr_pkg::COORD_BITS-1:0] hit_y;
  logic signed [hhr_pkg::COORD_BITS-1:0] hit_z;
  modport source (output valid, output hit_x, output hit_y, output hit_z, input ready);
  modport sink   (input valid, input hit_x, input hit_y, input hit_z, output ready);
endinterface

interface hhr_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [hhr_pkg::OW-1:0] radial_residual;
  logic signed [hhr_pkg::OW-1:0] height_residual;
  modport source (output valid, output radial_residual, output height_residual,
                  input ready);
  modport sink   (input valid, input radial_residual, input height_residual,
                  output ready);
endinterface

[design/helix_hit_residual_unit.sv]
// Helix hit residual unit: for each hit transaction (x, y, z in 1/256 units) returns the
// radial residual (rounded distance from the helix axis minus radius) and the height
// residual (hit height minus helix height at the hit azimuth, folded once by one pitch),
// both saturated. One transaction is accepted per cycle while the output is not stalled;
// results come out in order from the 32-step rotation pipeline that measures the azimuths,
// which runs beside the digit-per-stage square root, and then through the tail stages.
// Any stall on the result side freezes the whole pipeline. Configure only while idle.
module helix_hit_residual_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  hhr_in_if.sink                            in_ch,
  hhr_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_idx,
  input  logic [hhr_pkg::COORD_BITS-1:0]    cfg_data
);

  localparam int CB = hhr_pkg::COORD_BITS;
  localparam int AB = hhr_pkg::ANGLE_BITS;
  localparam int DW = hhr_pkg::DW;
  localparam int NST = hhr_pkg::NST;

  // configuration registers
  logic signed [CB-1:0] axis_x_r, axis_z_r, rise_r, start_x_r, start_z_r, start_y_r;
  logic [CB-2:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r  <= '0;
      axis_z_r  <= '0;
      radius_r  <= '0;
      rise_r    <= '0;
      start_x_r <= '0;
      start_z_r <= '0;
      start_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hhr_pkg::REG_AXIS_X:  axis_x_r  <= cfg_data;
        hhr_pkg::REG_AXIS_Z:  axis_z_r  <= cfg_data;
        hhr_pkg::REG_RADIUS:  radius_r  <= cfg_data[CB-2:0];
        hhr_pkg::REG_RISE:    rise_r    <= cfg_data;
        hhr_pkg::REG_START_X: start_x_r <= cfg_data;
        hhr_pkg::REG_START_Z: start_z_r <= cfg_data;
        hhr_pkg::REG_START_Y: start_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves together; hold everything while the result waits
  logic advance;
  logic out_v_r;
  assign advance     = !out_v_r || out_ch.ready;
  assign in_ch.ready = advance;

  // stage 0: offsets from the axis
  logic                 v0_r;
  logic signed [DW-1:0] dx0_r, dz0_r;
  logic signed [CB-1:0] hy0_r;

  // stage 1: squares and half plane fold
  logic                  v1_r;
  logic [DW-1:0]         ax_w, az_w;
  logic [2*DW-1:0]       sqx_r, sqz_r;
  hhr_pkg::cor_t         hp1_r, sp1_r;
  logic                  hz1_r, sz1_r;
  logic signed [CB-1:0]  hy1_r;
  logic signed [DW-1:0]  sdx_w, sdz_w;

  assign ax_w  = dx0_r[DW-1] ? DW'(-dx0_r) : DW'(dx0_r);
  assign az_w  = dz0_r[DW-1] ? DW'(-dz0_r) : DW'(dz0_r);
  assign sdx_w = DW'(start_x_r) - DW'(axis_x_r);
  assign sdz_w = DW'(start_z_r) - DW'(axis_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx0_r <= DW'(in_ch.hit_x) - DW'(axis_x_r);
      dz0_r <= DW'(in_ch.hit_z) - DW'(axis_z_r);
      hy0_r <= in_ch.hit_y;
      sqx_r <= (2*DW)'(ax_w) * (2*DW)'(ax_w);
      sqz_r <= (2*DW)'(az_w) * (2*DW)'(az_w);
      hp1_r <= hhr_pkg::cor_prep(dx0_r, dz0_r);
      sp1_r <= hhr_pkg::cor_prep(sdx_w, sdz_w);
      hz1_r <= (dx0_r == '0) && (dz0_r == '0);
      sz1_r <= (sdx_w == '0) && (sdz_w == '0);
      hy1_r <= hy0_r;
    end
  end

  // main stages: one rotation step per stage, plus one root digit per stage in stages 1 to NSQ
  hhr_pkg::stg_t st_r   [NST];
  hhr_pkg::stg_t st_nxt [NST];
  logic          sv_r   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        st_nxt[k].hit  = hhr_pkg::cor_step(hp1_r, 0);
        st_nxt[k].sta  = hhr_pkg::cor_step(sp1_r, 0);
        st_nxt[k].hz   = hz1_r;
        st_nxt[k].sz   = sz1_r;
        st_nxt[k].val  = hhr_pkg::SQW'(sqx_r) + hhr_pkg::SQW'(sqz_r);
        st_nxt[k].rem  = '0;
        st_nxt[k].root = '0;
        st_nxt[k].hy   = hy1_r;
      end
    end else begin : g_rest
      logic [hhr_pkg::RMW-1:0] rem_w, trial_w;
      always_comb begin
        st_nxt[k] = st_r[k-1];
        rem_w     = '0;
        trial_w   = '0;
        if (k < hhr_pkg::NCOR) begin
          st_nxt[k].hit = hhr_pkg::cor_step(st_r[k-1].hit, k);
          st_nxt[k].sta = hhr_pkg::cor_step(st_r[k-1].sta, k);
        end
        if (k <= hhr_pkg::NSQ) begin
          // bring down the next bit pair; subtract the trial if it fits
          rem_w   = {st_r[k-1].rem[hhr_pkg::RMW-3:0],
                     st_r[k-1].val[2*(hhr_pkg::NSQ-k) +: 2]};
          trial_w = {1'b0, st_r[k-1].root, 2'b01};
          if (rem_w >= trial_w) begin
            st_nxt[k].rem  = rem_w - trial_w;
            st_nxt[k].root = {st_r[k-1].root[hhr_pkg::RTW-2:0], 1'b1};
          end else begin
            st_nxt[k].rem  = rem_w;
            st_nxt[k].root = {st_r[k-1].root[hhr_pkg::RTW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (advance) begin
        sv_r[k] <= (k == 0) ? v1_r : sv_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // tail stages
  logic                          q1_v_r, q2_v_r, q3_v_r, q4_v_r;
  logic signed [AB:0]            d1_r;
  logic [hhr_pkg::OW-1:0]        rad1_r, rad2_r, rad3_r, rad4_r;
  logic [hhr_pkg::PW-1:0]        p1_r, p2_r, p3_r, p4_r;
  logic signed [CB:0]            hyq1_r, hyq2_r, hyq3_r;
  logic signed [hhr_pkg::QW-1:0] q2_r;
  logic signed [hhr_pkg::UW-1:0] hk3_r;
  logic [hhr_pkg::KB-1:0]        lk3_r;
  logic signed [hhr_pkg::RW-1:0] r4_r;

  hhr_pkg::stg_t                   last_w;
  logic signed [AB-1:0]            th_h_w, th_s_w;
  logic [hhr_pkg::RTW:0]           rootf_w;
  logic signed [CB:0]              rs_w;
  logic [CB:0]                     arise_w;
  logic [CB+hhr_pkg::KB:0]         pp_w;
  logic signed [hhr_pkg::QW-16-1:0] h_w;
  logic [15+hhr_pkg::KB:0]         lp_w;
  logic signed [hhr_pkg::UW-1:0]   u_w;
  logic signed [hhr_pkg::UW-AB-1:0] ht_w;
  logic signed [hhr_pkg::RW:0]     ar_w;
  logic signed [hhr_pkg::RW:0]     rf_w;
  logic [hhr_pkg::OW-1:0]          height_w;

  always_comb begin
    last_w  = st_r[NST-1];
    th_h_w  = hhr_pkg::ang_round(last_w.hit.a, last_w.hz);
    th_s_w  = hhr_pkg::ang_round(last_w.sta.a, last_w.sz);
    // round to nearest: bump when the remainder passes the root
    rootf_w = (hhr_pkg::RTW+1)'(last_w.root)
            + (((hhr_pkg::RTW+1)'(last_w.rem) > (hhr_pkg::RTW+1)'(last_w.root)) ? 1'b1 : 1'b0);
    rs_w    = (CB+1)'(rise_r);
    arise_w = rs_w[CB] ? (CB+1)'(-rs_w) : (CB+1)'(rs_w);
    pp_w    = (CB+hhr_pkg::KB+1)'(arise_w) * (CB+hhr_pkg::KB+1)'(hhr_pkg::TWO_PI_Q16)
            + (CB+hhr_pkg::KB+1)'(32768);
    h_w     = $signed(q2_r[hhr_pkg::QW-1:16]);
    lp_w    = (16+hhr_pkg::KB)'(q2_r[15:0]) * (16+hhr_pkg::KB)'(hhr_pkg::TWO_PI_Q16);
    u_w     = hk3_r + hhr_pkg::UW'(1 << (AB-1)) + hhr_pkg::UW'(lk3_r);
    ht_w    = $signed(u_w[hhr_pkg::UW-1:AB]);
    // fold once by one pitch when the residual passes half a pitch
    ar_w    = r4_r[hhr_pkg::RW-1] ? -(hhr_pkg::RW+1)'(r4_r) : (hhr_pkg::RW+1)'(r4_r);
    rf_w    = (hhr_pkg::RW+1)'(r4_r);
    if ((ar_w <<< 1) > $signed((hhr_pkg::RW+1)'(p4_r))) begin
      if (r4_r > 0) rf_w = rf_w - $signed((hhr_pkg::RW+1)'(p4_r));
      else          rf_w = rf_w + $signed((hhr_pkg::RW+1)'(p4_r));
    end
    height_w = hhr_pkg::sat_out(64'(rf_w));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r  <= 1'b0;
      q2_v_r  <= 1'b0;
      q3_v_r  <= 1'b0;
      q4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      q1_v_r  <= sv_r[NST-1];
      q2_v_r  <= q1_v_r;
      q3_v_r  <= q2_v_r;
      q4_v_r  <= q3_v_r;
      out_v_r <= q4_v_r;
    end
  end

  logic [hhr_pkg::OW-1:0] rad_out_r, hgt_out_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      // azimuth difference, radial residual, pitch
      d1_r   <= (AB+1)'(th_h_w) - (AB+1)'(th_s_w);
      rad1_r <= hhr_pkg::sat_out($signed(64'(rootf_w)) - $signed(64'(radius_r)));
      p1_r   <= pp_w[CB+hhr_pkg::KB:16];
      hyq1_r <= (CB+1)'(last_w.hy) - (CB+1)'(start_y_r);
      // rise times angle
      q2_r   <= hhr_pkg::QW'(rise_r) * hhr_pkg::QW'(d1_r);
      rad2_r <= rad1_r;
      p2_r   <= p1_r;
      hyq2_r <= hyq1_r;
      // scale by 2*pi in two partial products
      hk3_r  <= hhr_pkg::UW'(h_w) * hhr_pkg::UW'(hhr_pkg::TWO_PI_Q16);
      lk3_r  <= lp_w[15+hhr_pkg::KB:16];
      rad3_r <= rad2_r;
      p3_r   <= p2_r;
      hyq3_r <= hyq2_r;
      // raw height residual
      r4_r   <= hhr_pkg::RW'(hyq3_r) - hhr_pkg::RW'(ht_w);
      rad4_r <= rad3_r;
      p4_r   <= p3_r;
      // output register
      rad_out_r <= rad4_r;
      hgt_out_r <= height_w;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.radial_residual = rad_out_r;
  assign out_ch.height_residual = hgt_out_r;

endmodule
